// ===== hw/rtl/fsc_pkg.sv =====
// Shared types and constants for the fuzzy speed controller.
package fsc_pkg;

    localparam int DIST_W  = 13;
    localparam int CURVE_W = 14;
    localparam int SPEED_W = 12;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 14;

    localparam logic [CFG_IW-1:0] REG_DIST_LOW   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_DIST_MID   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DIST_HIGH  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_CURVE_LOW  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_CURVE_HIGH = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SPEED_LOW  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_SPEED_HIGH = 3'd6;
    localparam logic [CFG_IW-1:0] REG_MAX_STEP   = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       memb_step;
        logic       memb_div_write;
        logic       acc;
        logic       final_start;
        logic       hold;
        logic       cand_write;
        logic       out_load;
        logic [2:0] k;
        logic [1:0] ri;
        logic [2:0] rj;
    } fsc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;
        logic div_done;
        logic den_zero;
    } fsc_sts_t;

endpackage

// ===== hw/rtl/fsc_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module fsc_div #(
    parameter int DVW = 36,
    parameter int DSW = 20,
    parameter int QB  = 13
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic [QB-1:0]  quotient,
    output logic           done
);
    localparam int XW = (DVW > DSW + QB) ? DVW : DSW + QB;
    localparam int CW = $clog2(QB + 1);

    logic [XW-1:0] rem_reg;
    logic [XW-1:0] dsh_reg;
    logic [QB-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic          ge;
    logic [XW-1:0] diff;

    assign ge       = rem_reg >= dsh_reg;
    assign diff     = rem_reg - dsh_reg;
    assign quotient = q_reg;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg <= XW'(dividend);
                dsh_reg <= XW'(divisor) << (QB - 1);
                cnt_reg <= CW'(QB);
            end else if (cnt_reg != '0) begin
                rem_reg <= ge ? diff : rem_reg;
                q_reg   <= {q_reg[QB-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/fsc_datapath.sv =====
// Datapath: configuration, clamps, grades, rule sums, divider and rate limit.
module fsc_datapath #(
    parameter int FRAC_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [fsc_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [fsc_pkg::CFG_DW-1:0]     cfg_data,
    input  logic [fsc_pkg::DIST_W-1:0]     s_distance,
    input  logic signed [fsc_pkg::CURVE_W-1:0] s_steering,
    input  fsc_pkg::fsc_cmd_t              cmd,
    output fsc_pkg::fsc_sts_t              sts,
    output logic [fsc_pkg::SPEED_W-1:0]    m_speed,
    output logic                           m_rate_limited
);
    import fsc_pkg::*;

    localparam int W   = FRAC_BITS + 10;
    localparam int MW  = FRAC_BITS + 1;
    localparam int LW  = (FRAC_BITS > 12) ? FRAC_BITS : 12;
    localparam int QB  = LW + 1;
    localparam int DVW = FRAC_BITS + 24;
    localparam int DSW = FRAC_BITS + 8;
    localparam int NW  = MW + LW + 4;
    localparam int DNW = FRAC_BITS + 5;
    localparam int EW  = LW + 3;

    localparam int QONE = 1 << FRAC_BITS;
    localparam int CD   = (QONE + 50) / 100;
    localparam int CC   = (QONE + 100) / 200;
    localparam int C08  = (4 * QONE + 2) / 5;
    localparam int C05  = (QONE + 10) / 20;
    localparam int C15  = (3 * QONE + 10) / 20;
    localparam int C30  = (3 * QONE + 5) / 10;

    localparam logic signed [W-1:0] CD_W  = W'(CD);
    localparam logic signed [W-1:0] CC_W  = W'(CC);
    localparam logic signed [W-1:0] C08_W = W'(C08);
    localparam logic [LW-1:0] L05 = LW'(C05);
    localparam logic [LW-1:0] L15 = LW'(C15);
    localparam logic [LW-1:0] L30 = LW'(C30);
    localparam logic [MW-1:0] ONE_M = MW'(QONE);

    logic [DIST_W-1:0]         dist_low_reg, dist_mid_reg, dist_high_reg;
    logic signed [CURVE_W-1:0] curve_low_reg, curve_high_reg;
    logic [SPEED_W-1:0]        speed_low_reg, speed_high_reg, max_step_reg;
    logic [SPEED_W-1:0]        last_speed_reg;

    logic signed [W-1:0] d_reg, s_reg;
    logic [MW-1:0]       mg_reg [0:2];
    logic [MW-1:0]       mc_reg [0:4];
    logic [NW-1:0]       num_reg;
    logic [DNW-1:0]      den_reg;
    logic [LW:0]         cand_reg;
    logic [SPEED_W-1:0]  m_speed_reg;
    logic                m_rl_reg;

    logic signed [W-1:0] d_in, s_in, d_c1, d_cl, s_c1, s_cl;
    logic signed [W-1:0] dlo_w, dmid_w, dhi_w, clo_w, chi_w;
    logic signed [W-1:0] ga, gc, ca, cc, cn, cp;
    logic signed [W-1:0] x, a, b, c, num_m, den_m;
    logic                trivial;
    logic [MW-1:0]       triv_val;
    logic [DVW-1:0]      dvd;
    logic [DSW-1:0]      dvs;
    logic [QB-1:0]       quo;
    logic                div_done;
    logic                div_start;
    logic [MW-1:0]       wg, wc, w;
    logic [LW-1:0]       lev;
    logic [MW+LW-1:0]    prod;
    logic signed [EW-1:0] cand_e, last_e, step_e, dif, res;
    logic                lim;
    logic [SPEED_W-1:0]  res_sat;

    assign dlo_w  = W'(dist_low_reg);
    assign dmid_w = W'(dist_mid_reg);
    assign dhi_w  = W'(dist_high_reg);
    assign clo_w  = W'(curve_low_reg);
    assign chi_w  = W'(curve_high_reg);
    assign ga = dlo_w - CD_W;
    assign gc = dhi_w + CD_W;
    assign ca = clo_w - CC_W;
    assign cc = chi_w + CC_W;
    assign cn = -C08_W;
    assign cp = C08_W;

    // Clamp: low limit first, then high limit, so the high limit wins.
    always_comb begin
        d_in = W'(s_distance);
        s_in = W'(s_steering);
        d_c1 = (d_in < dlo_w) ? dlo_w : d_in;
        d_cl = (d_c1 > dhi_w) ? dhi_w : d_c1;
        s_c1 = (s_in < clo_w) ? clo_w : s_in;
        s_cl = (s_c1 > chi_w) ? chi_w : s_c1;
    end

    // Triangle set points for grade k.
    always_comb begin
        x = d_reg;
        a = ga;
        b = ga;
        c = dmid_w;
        case (cmd.k)
            3'd0: begin a = ga;     b = ga;     c = dmid_w; end
            3'd1: begin a = ga;     b = dmid_w; c = gc;     end
            3'd2: begin a = dmid_w; b = gc;     c = gc;     end
            3'd3: begin x = s_reg; a = ca; b = ca; c = cn; end
            3'd4: begin x = s_reg; a = ca; b = cn; c = '0; end
            3'd5: begin x = s_reg; a = cn; b = '0; c = cp; end
            3'd6: begin x = s_reg; a = '0; b = cp; c = cc; end
            3'd7: begin x = s_reg; a = cp; b = cc; c = cc; end
            default: begin x = d_reg; end
        endcase
        trivial  = 1'b1;
        triv_val = '0;
        if (x == b) begin
            triv_val = ONE_M;
        end else if (x <= a || x >= c) begin
            triv_val = '0;
        end else begin
            trivial = 1'b0;
        end
        num_m = (x < b) ? x - a : c - x;
        den_m = (x < b) ? b - a : c - b;
    end

    always_comb begin
        if (cmd.final_start) begin
            dvd = DVW'(num_reg) + DVW'(den_reg >> 1);
            dvs = DSW'(den_reg);
        end else begin
            dvd = DVW'($unsigned(num_m)) << FRAC_BITS;
            dvs = DSW'($unsigned(den_m));
        end
    end

    assign div_start = (cmd.memb_step && !trivial) || cmd.final_start;

    fsc_div #(.DVW(DVW), .DSW(DSW), .QB(QB)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .quotient (quo),
        .done     (div_done)
    );

    // Rule strength and level.
    always_comb begin
        wg = mg_reg[cmd.ri];
        wc = mc_reg[cmd.rj];
        w  = (wg < wc) ? wg : wc;
        lev = LW'(speed_low_reg);
        case (cmd.ri)
            2'd1: lev = (cmd.rj == 3'd2) ? L30 :
                        ((cmd.rj == 3'd1 || cmd.rj == 3'd3) ? L15 : L05);
            2'd2: lev = (cmd.rj == 3'd2) ? LW'(speed_high_reg) :
                        ((cmd.rj == 3'd1 || cmd.rj == 3'd3) ? L30 : L15);
            default: lev = LW'(speed_low_reg);
        endcase
        prod = w * lev;
    end

    // Symmetric rate limit, then saturation to the speed range.
    always_comb begin
        cand_e = EW'(cand_reg);
        last_e = EW'(last_speed_reg);
        step_e = EW'(max_step_reg);
        dif    = cand_e - last_e;
        lim    = 1'b0;
        res    = cand_e;
        if (dif > step_e) begin
            res = last_e + step_e;
            lim = 1'b1;
        end else if (-dif > step_e) begin
            res = last_e - step_e;
            lim = 1'b1;
        end
        if (res < 0) begin
            res_sat = '0;
        end else if (res > EW'(4095)) begin
            res_sat = '1;
        end else begin
            res_sat = SPEED_W'(res);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_low_reg   <= 13'd451;
            dist_mid_reg   <= 13'd2048;
            dist_high_reg  <= 13'd4055;
            curve_low_reg  <= -14'sd6124;
            curve_high_reg <= 14'sd6124;
            speed_low_reg  <= 12'd82;
            speed_high_reg <= 12'd2048;
            max_step_reg   <= 12'd410;
            last_speed_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DIST_LOW:   dist_low_reg   <= cfg_data[DIST_W-1:0];
                    REG_DIST_MID:   dist_mid_reg   <= cfg_data[DIST_W-1:0];
                    REG_DIST_HIGH:  dist_high_reg  <= cfg_data[DIST_W-1:0];
                    REG_CURVE_LOW:  curve_low_reg  <= cfg_data;
                    REG_CURVE_HIGH: curve_high_reg <= cfg_data;
                    REG_SPEED_LOW:  speed_low_reg  <= cfg_data[SPEED_W-1:0];
                    REG_SPEED_HIGH: speed_high_reg <= cfg_data[SPEED_W-1:0];
                    REG_MAX_STEP:   max_step_reg   <= cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.out_load) begin
                last_speed_reg <= res_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            d_reg   <= d_cl;
            s_reg   <= s_cl;
            num_reg <= '0;
            den_reg <= '0;
        end
        if ((cmd.memb_step && trivial) || cmd.memb_div_write) begin
            if (cmd.k < 3'd3) begin
                mg_reg[cmd.k[1:0]] <= cmd.memb_div_write ? MW'(quo) : triv_val;
            end else begin
                mc_reg[3'(cmd.k - 3'd3)] <= cmd.memb_div_write ? MW'(quo) : triv_val;
            end
        end
        if (cmd.acc) begin
            num_reg <= num_reg + NW'(prod);
            den_reg <= den_reg + DNW'(w);
        end
        if (cmd.hold) begin
            cand_reg <= (LW + 1)'(last_speed_reg);
        end
        if (cmd.cand_write) begin
            cand_reg <= quo;
        end
        if (cmd.out_load) begin
            m_speed_reg <= res_sat;
            m_rl_reg    <= lim;
        end
    end

    assign sts.trivial  = trivial;
    assign sts.div_done = div_done;
    assign sts.den_zero = (den_reg == '0);
    assign m_speed        = m_speed_reg;
    assign m_rate_limited = m_rl_reg;
endmodule

// ===== hw/rtl/fsc_ctrl.sv =====
// Controller state machine that sequences grades, rules, division and output.
module fsc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  fsc_pkg::fsc_sts_t sts,
    output fsc_pkg::fsc_cmd_t cmd
);
    import fsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MEMB, ST_MWAIT, ST_RULE, ST_FINAL, ST_FWAIT, ST_LIMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [1:0] ri_reg, ri_next;
    logic [2:0] rj_reg, rj_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        cmd.k        = k_reg;
        cmd.ri       = ri_reg;
        cmd.rj       = rj_reg;
        state_next   = state_reg;
        k_next       = k_reg;
        ri_next      = ri_reg;
        rj_next      = rj_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    k_next     = '0;
                    state_next = ST_MEMB;
                end
            end
            ST_MEMB: begin
                cmd.memb_step = 1'b1;
                if (!sts.trivial) begin
                    state_next = ST_MWAIT;
                end else if (k_reg == 3'd7) begin
                    ri_next = '0;
                    rj_next = '0;
                    state_next = ST_RULE;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_MWAIT: begin
                if (sts.div_done) begin
                    cmd.memb_div_write = 1'b1;
                    if (k_reg == 3'd7) begin
                        ri_next = '0;
                        rj_next = '0;
                        state_next = ST_RULE;
                    end else begin
                        k_next = k_reg + 3'd1;
                        state_next = ST_MEMB;
                    end
                end
            end
            ST_RULE: begin
                cmd.acc = 1'b1;
                if (rj_reg == 3'd4) begin
                    rj_next = '0;
                    if (ri_reg == 2'd2) begin
                        state_next = ST_FINAL;
                    end else begin
                        ri_next = ri_reg + 2'd1;
                    end
                end else begin
                    rj_next = rj_reg + 3'd1;
                end
            end
            ST_FINAL: begin
                if (sts.den_zero) begin
                    cmd.hold   = 1'b1;
                    state_next = ST_LIMIT;
                end else begin
                    cmd.final_start = 1'b1;
                    state_next      = ST_FWAIT;
                end
            end
            ST_FWAIT: begin
                if (sts.div_done) begin
                    cmd.cand_write = 1'b1;
                    state_next     = ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            ri_reg      <= '0;
            rj_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            ri_reg      <= ri_next;
            rj_reg      <= rj_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while an item is in work");

    a_result_from_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_LIMIT))
        else $error("result raised outside the limit step");

    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == ST_MWAIT || state_reg == ST_FWAIT))
        else $error("divider finished while nobody waited");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.memb_step, cmd.memb_div_write, cmd.acc,
                  cmd.final_start, cmd.hold, cmd.cand_write, cmd.out_load}))
        else $error("more than one datapath command at once");
endmodule

// ===== hw/rtl/fuzzy_speed_controller.sv =====
// Top level of the zero-order Sugeno fuzzy speed controller.
// Each item walks the grades, the rule sums, the final division (none when no rule
// fires) and the rate limit. The bit-serial shared divider, with QB = max(FRAC_BITS, 12)
// + 1 quotient bits, serves each grade that is not a set corner and the final average.
// No new item is taken until the result is loaded; m_ready low stalls only the last step.
// Synchronous active-low reset restores register defaults, zeroes the held speed, drops results.
module fuzzy_speed_controller #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [fsc_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [fsc_pkg::CFG_DW-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [fsc_pkg::DIST_W-1:0]         s_distance,
    input  logic signed [fsc_pkg::CURVE_W-1:0] s_steering,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fsc_pkg::SPEED_W-1:0]        m_speed,
    output logic                               m_rate_limited
);
    import fsc_pkg::*;

    // The controller walks eight grades (trivial corners skip the divider),
    // fifteen rule sums, at most one weighted-average division and the rate limit.
    fsc_cmd_t cmd;
    fsc_sts_t sts;

    fsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds configuration, the held speed and the output item.
    fsc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_distance     (s_distance),
        .s_steering     (s_steering),
        .cmd            (cmd),
        .sts            (sts),
        .m_speed        (m_speed),
        .m_rate_limited (m_rate_limited)
    );
endmodule
